// ===== design/ptba_pkg.sv =====
package ptba_pkg;

  localparam int unsigned NumPeersDefault = 16;

  localparam int unsigned OpW     = 2;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 8;
  localparam int unsigned MRateW  = 8;
  localparam int unsigned CRateW  = 10;
  localparam int unsigned MCredW  = 34;
  localparam int unsigned CCredW  = 30;
  localparam int unsigned MPerW   = 26;
  localparam int unsigned CPerW   = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 16;

  localparam logic [MPerW-1:0] MPeriod = MPerW'(60_000_000);
  localparam logic [CPerW-1:0] CPeriod = CPerW'(1_000_000);

  typedef enum logic [OpW-1:0] {
    OP_MANIFEST   = 2'd0,
    OP_CHUNK      = 2'd1,
    OP_RELEASE    = 2'd2,
    OP_DISCONNECT = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_ADMITTED   = 3'd0,
    ST_GLOBAL_CAP = 3'd1,
    ST_PEER_CAP   = 3'd2,
    ST_NO_TOKEN   = 3'd3,
    ST_DONE       = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MANIFEST_RATE = 2'd0,
    CFG_CHUNK_RATE    = 2'd1,
    CFG_MAX_GLOBAL    = 2'd2,
    CFG_MAX_PEER      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [MRateW-1:0] m_rate;
    logic [CRateW-1:0] c_rate;
    logic [CountW-1:0] max_global;
    logic [CountW-1:0] max_peer;
  } cfg_t;

  typedef struct packed {
    logic [MCredW-1:0] m_credit;
    logic [TimeW-1:0]  m_time;
    logic [CCredW-1:0] c_credit;
    logic [TimeW-1:0]  c_time;
    logic [CountW-1:0] active;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic              valid_we;
    logic              valid;
    entry_t            ent;
    logic [CountW-1:0] global_cnt;
    logic              admitted;
    status_e           status;
  } upd_t;

endpackage

// ===== design/peer_token_bucket_admission_core.sv =====
// On acceptance a request is registered into the evaluation stage; its result is registered
// on commit, which waits while the output stalls. Throughput: one request per cycle unless
// the output stalls, set by the single read-modify-write of the per-peer table in that stage.
// Reset clears all slot valid bits, the global transfer count and the pipeline
// valids, and loads the configuration registers with their defaults.
module peer_token_bucket_admission_core import ptba_pkg::*; #(
  parameter int unsigned NUM_PEERS = NumPeersDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0: opcode[1:0], peer_slot[5:2], now_us[53:6], zero fill.
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // Fields from bit 0: admitted[0], status[3:1], global_active[11:4], zero fill.
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned IdxW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;

  cfg_t              cfg_q;
  logic [NUM_PEERS-1:0] slot_valid_q;
  logic [CountW-1:0] global_q;
  entry_t            mem [NUM_PEERS];

  logic              v1_q, v2_q;
  op_e               op_q;
  logic              in_range_q;
  logic [IdxW-1:0]   idx_q;
  logic [TimeW-1:0]  now_q;
  entry_t            rd_q;
  logic [OutDataW-1:0] out_q;

  logic              acc, commit, acc_in_range;
  logic [SlotW-1:0]  acc_slot;
  logic [IdxW-1:0]   acc_idx;
  upd_t              upd;

  assign acc_slot     = s_axis_tdata[OpW+SlotW-1:OpW];
  assign acc_in_range = (9'(acc_slot) < 9'(NUM_PEERS));
  assign acc_idx      = acc_in_range ? IdxW'(acc_slot) : '0;

  assign commit        = v1_q && (!v2_q || m_axis_tready);
  assign s_axis_tready = !v1_q || commit;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = out_q;

  ptba_eval u_eval (
    .cfg_i        (cfg_q),
    .op_i         (op_q),
    .in_range_i   (in_range_q),
    .slot_valid_i (slot_valid_q[idx_q]),
    .ent_i        (rd_q),
    .global_i     (global_q),
    .now_i        (now_q),
    .upd_o        (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.m_rate     <= MRateW'(6);
      cfg_q.c_rate     <= CRateW'(32);
      cfg_q.max_global <= CountW'(8);
      cfg_q.max_peer   <= CountW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MANIFEST_RATE: cfg_q.m_rate     <= cfg_wdata_i[MRateW-1:0];
        CFG_CHUNK_RATE:    cfg_q.c_rate     <= cfg_wdata_i[CRateW-1:0];
        CFG_MAX_GLOBAL:    cfg_q.max_global <= cfg_wdata_i[CountW-1:0];
        CFG_MAX_PEER:      cfg_q.max_peer   <= cfg_wdata_i[CountW-1:0];
        default:           cfg_q            <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      slot_valid_q <= '0;
      global_q     <= '0;
    end else begin
      if (acc) begin
        v1_q <= 1'b1;
      end else if (commit) begin
        v1_q <= 1'b0;
      end
      if (commit) begin
        v2_q     <= 1'b1;
        global_q <= upd.global_cnt;
        if (upd.valid_we) begin
          slot_valid_q[idx_q] <= upd.valid;
        end
      end else if (m_axis_tready) begin
        v2_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q       <= op_e'(s_axis_tdata[OpW-1:0]);
      in_range_q <= acc_in_range;
      idx_q      <= acc_idx;
      now_q      <= s_axis_tdata[OpW+SlotW+TimeW-1:OpW+SlotW];
      if (commit && upd.we && idx_q == acc_idx) begin
        rd_q <= upd.ent;
      end else begin
        rd_q <= mem[acc_idx];
      end
    end
    if (commit) begin
      out_q <= {OutDataW'(0) | OutDataW'({upd.global_cnt, upd.status, upd.admitted})};
      if (upd.we) begin
        mem[idx_q] <= upd.ent;
      end
    end
  end

endmodule

// ===== design/ptba_eval.sv =====
module ptba_eval import ptba_pkg::*; (
  input  cfg_t              cfg_i,
  input  op_e               op_i,
  input  logic              in_range_i,
  input  logic              slot_valid_i,
  input  entry_t            ent_i,
  input  logic [CountW-1:0] global_i,
  input  logic [TimeW-1:0]  now_i,
  output upd_t              upd_o
);

  logic [MCredW-1:0] cap_m;
  logic [CCredW-1:0] cap_c;
  entry_t            base;
  logic [TimeW-1:0]  m_el, c_el;
  logic [MPerW-1:0]  m_el_c;
  logic [CPerW-1:0]  c_el_c;
  logic [MCredW-1:0] m_prod, m_fill, m_left;
  logic [CCredW-1:0] c_prod, c_fill, c_left;
  logic [MCredW:0]   m_sum;
  logic [CCredW:0]   c_sum;
  logic              m_ok, c_ok;

  assign cap_m = MCredW'(cfg_i.m_rate) * MCredW'(MPeriod);
  assign cap_c = CCredW'(cfg_i.c_rate) * CCredW'(CPeriod);

  always_comb begin
    if (slot_valid_i) begin
      base = ent_i;
    end else begin
      base.m_credit = cap_m;
      base.m_time   = '0;
      base.c_credit = cap_c;
      base.c_time   = '0;
      base.active   = '0;
    end
  end

  // Manifest bucket refill and take.
  always_comb begin
    m_el   = (now_i > base.m_time) ? now_i - base.m_time : '0;
    m_el_c = (m_el >= TimeW'(MPeriod)) ? MPeriod : m_el[MPerW-1:0];
    m_prod = MCredW'(m_el_c) * MCredW'(cfg_i.m_rate);
    m_sum  = (MCredW+1)'(base.m_credit) + (MCredW+1)'(m_prod);
    if (base.m_time != '0) begin
      m_fill = (m_sum < (MCredW+1)'(cap_m)) ? m_sum[MCredW-1:0] : cap_m;
    end else begin
      m_fill = base.m_credit;
    end
    m_ok   = m_fill >= MCredW'(MPeriod);
    m_left = m_ok ? m_fill - MCredW'(MPeriod) : m_fill;
  end

  // Chunk bucket refill and take.
  always_comb begin
    c_el   = (now_i > base.c_time) ? now_i - base.c_time : '0;
    c_el_c = (c_el >= TimeW'(CPeriod)) ? CPeriod : c_el[CPerW-1:0];
    c_prod = CCredW'(c_el_c) * CCredW'(cfg_i.c_rate);
    c_sum  = (CCredW+1)'(base.c_credit) + (CCredW+1)'(c_prod);
    if (base.c_time != '0) begin
      c_fill = (c_sum < (CCredW+1)'(cap_c)) ? c_sum[CCredW-1:0] : cap_c;
    end else begin
      c_fill = base.c_credit;
    end
    c_ok   = c_fill >= CCredW'(CPeriod);
    c_left = c_ok ? c_fill - CCredW'(CPeriod) : c_fill;
  end

  always_comb begin
    upd_o.we         = 1'b0;
    upd_o.valid_we   = 1'b0;
    upd_o.valid      = slot_valid_i;
    upd_o.ent        = base;
    upd_o.global_cnt = global_i;
    upd_o.admitted   = 1'b0;
    upd_o.status     = ST_DONE;
    if (!in_range_i) begin
      if (op_i == OP_MANIFEST || op_i == OP_CHUNK) begin
        upd_o.status = ST_NO_TOKEN;
      end
    end else begin
      unique case (op_i)
        OP_MANIFEST: begin
          upd_o.we              = 1'b1;
          upd_o.valid_we        = 1'b1;
          upd_o.valid           = 1'b1;
          upd_o.ent.m_credit    = m_left;
          upd_o.ent.m_time      = now_i;
          upd_o.admitted        = m_ok;
          upd_o.status          = m_ok ? ST_ADMITTED : ST_NO_TOKEN;
        end
        OP_CHUNK: begin
          if (global_i >= cfg_i.max_global) begin
            upd_o.status = ST_GLOBAL_CAP;
          end else begin
            upd_o.we       = 1'b1;
            upd_o.valid_we = 1'b1;
            upd_o.valid    = 1'b1;
            if (base.active >= cfg_i.max_peer) begin
              upd_o.status = ST_PEER_CAP;
            end else begin
              upd_o.ent.c_credit = c_left;
              upd_o.ent.c_time   = now_i;
              upd_o.admitted     = c_ok;
              upd_o.status       = c_ok ? ST_ADMITTED : ST_NO_TOKEN;
              if (c_ok) begin
                upd_o.ent.active = base.active + CountW'(1);
                upd_o.global_cnt = global_i + CountW'(1);
              end
            end
          end
        end
        OP_RELEASE: begin
          if (slot_valid_i) begin
            upd_o.we = 1'b1;
            if (base.active != '0) begin
              upd_o.ent.active = base.active - CountW'(1);
            end
            if (global_i != '0) begin
              upd_o.global_cnt = global_i - CountW'(1);
            end
          end
        end
        OP_DISCONNECT: begin
          if (slot_valid_i) begin
            upd_o.valid_we = 1'b1;
            upd_o.valid    = 1'b0;
            if (base.active != '0 && global_i >= base.active) begin
              upd_o.global_cnt = global_i - base.active;
            end
          end
        end
        default: begin
          upd_o.status = ST_DONE;
        end
      endcase
    end
  end

endmodule
